### rtl/ncre_pkg.sv
// ----------------------------------------------------------------------------
// ncre_pkg
// Shared types and constants for the nlfsr cipher round engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ncre_pkg;

    localparam int KEY_W   = 64;
    localparam int BLOCK_W = 32;
    localparam int KIDX_W  = 6;
    localparam int ROUND_W = 10;

    // five-input nonlinear function, indexed by the tap bits
    localparam logic [31:0] NLF_TABLE = 32'h3A5C742E;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } ctrl_state_t;

    typedef struct packed {
        logic load;     // take a new item into the working registers
        logic step;     // run one round
        logic capture;  // move the working block into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic rounds_done;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/nlfsr_cipher_round_engine.sv
// ----------------------------------------------------------------------------
// nlfsr_cipher_round_engine
// Runs a requested number of rounds of a 32-bit nlfsr block cipher with a
// 64-bit key, forward for encrypt or inverse for decrypt.
// ----------------------------------------------------------------------------
//
//  channel | dir | ports                         | beat contents
//  --------+-----+-------------------------------+-------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata[111:0] s_tuser | key, block, offset, rounds
//  m_      | out | m_tvalid m_tready m_tdata[31:0]          | block_out
//
//  one round per cycle through a single shared round unit: each item goes
//  through load, rounds and hand-off to the output register before the next
//  accept; the hand-off waits until the output register is free or being read.
//  the result sits in its own output register, so a new beat is accepted
//  while the previous result is still stalled on m_tready.
//  reset (aresetn low, synchronous) clears the sequencer and output valid.
//
`default_nettype none

module nlfsr_cipher_round_engine (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // [63:0] cipher_key, [95:64] block_in, [101:96] key_offset,
    // [111:102] round_count
    input  wire logic [111:0]  s_tdata,
    // [0] operation
    input  wire logic          s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // [31:0] block_out
    output logic [31:0]        m_tdata
);

    ncre_pkg::dp_cmd_t    cmd;
    ncre_pkg::dp_status_t sts;

    ncre_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ncre_datapath u_datapath (
        .aclk         (aclk),
        .cmd          (cmd),
        .sts          (sts),
        .in_operation (s_tuser),
        .in_key       (s_tdata[63:0]),
        .in_block     (s_tdata[95:64]),
        .in_offset    (s_tdata[101:96]),
        .in_rounds    (s_tdata[111:102]),
        .out_block    (m_tdata)
    );

endmodule

`default_nettype wire

### rtl/ncre_datapath.sv
// ----------------------------------------------------------------------------
// ncre_datapath
// Working block, key, key-bit index and round counter; one round per step.
// ----------------------------------------------------------------------------
`default_nettype none

module ncre_datapath (
    input  wire logic                             aclk,
    input  wire ncre_pkg::dp_cmd_t                cmd,
    output ncre_pkg::dp_status_t                  sts,
    input  wire logic                             in_operation,
    input  wire logic [ncre_pkg::KEY_W-1:0]       in_key,
    input  wire logic [ncre_pkg::BLOCK_W-1:0]     in_block,
    input  wire logic [ncre_pkg::KIDX_W-1:0]      in_offset,
    input  wire logic [ncre_pkg::ROUND_W-1:0]     in_rounds,
    output logic      [ncre_pkg::BLOCK_W-1:0]     out_block
);

    logic                             op_reg;
    logic [ncre_pkg::KEY_W-1:0]       key_reg;
    logic [ncre_pkg::BLOCK_W-1:0]     blk_reg, blk_next;
    logic [ncre_pkg::KIDX_W-1:0]      kidx_reg, kidx_next;
    logic [ncre_pkg::ROUND_W-1:0]     cnt_reg;
    logic [ncre_pkg::BLOCK_W-1:0]     out_reg;

    logic [ncre_pkg::KIDX_W-1:0]      kidx_start;
    logic [4:0]                       nlf_idx;
    logic                             nlf_bit;
    logic                             key_bit;
    logic                             new_bit;

    // decrypt starts at the last round's key bit, offset + count - 1 mod 64
    always_comb begin
        if (in_operation == ncre_pkg::OP_DECRYPT) begin
            kidx_start = in_offset + in_rounds[ncre_pkg::KIDX_W-1:0]
                         - {{(ncre_pkg::KIDX_W-1){1'b0}}, 1'b1};
        end else begin
            kidx_start = in_offset;
        end
    end

    always_comb begin
        key_bit = key_reg[kidx_reg];
        if (op_reg == ncre_pkg::OP_DECRYPT) begin
            nlf_idx   = {blk_reg[30], blk_reg[25], blk_reg[19], blk_reg[8], blk_reg[0]};
            nlf_bit   = ncre_pkg::NLF_TABLE[nlf_idx];
            new_bit   = blk_reg[31] ^ nlf_bit ^ key_bit ^ blk_reg[15];
            blk_next  = {blk_reg[30:0], new_bit};
            kidx_next = kidx_reg - {{(ncre_pkg::KIDX_W-1){1'b0}}, 1'b1};
        end else begin
            nlf_idx   = {blk_reg[31], blk_reg[26], blk_reg[20], blk_reg[9], blk_reg[1]};
            nlf_bit   = ncre_pkg::NLF_TABLE[nlf_idx];
            new_bit   = nlf_bit ^ key_bit ^ blk_reg[16] ^ blk_reg[0];
            blk_next  = {new_bit, blk_reg[31:1]};
            kidx_next = kidx_reg + {{(ncre_pkg::KIDX_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_operation;
            key_reg  <= in_key;
            blk_reg  <= in_block;
            kidx_reg <= kidx_start;
            cnt_reg  <= in_rounds;
        end else if (cmd.step) begin
            blk_reg  <= blk_next;
            kidx_reg <= kidx_next;
            cnt_reg  <= cnt_reg - {{(ncre_pkg::ROUND_W-1){1'b0}}, 1'b1};
        end
        if (cmd.capture) begin
            out_reg <= blk_reg;
        end
    end

    assign sts.rounds_done = (cnt_reg == '0);
    assign out_block       = out_reg;

endmodule

`default_nettype wire

### rtl/ncre_ctrl.sv
// ----------------------------------------------------------------------------
// ncre_ctrl
// Round sequencer and output valid tracking for the cipher round engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ncre_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output ncre_pkg::dp_cmd_t          cmd,
    input  wire ncre_pkg::dp_status_t  sts
);

    ncre_pkg::ctrl_state_t state_reg, state_next;
    logic                  valid_reg, valid_next;
    logic                  slot_free;

    assign slot_free = !valid_reg || m_tready;
    assign s_tready  = (state_reg == ncre_pkg::ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.capture = 1'b0;
        case (state_reg)
            ncre_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ncre_pkg::ST_RUN;
                end
            end
            ncre_pkg::ST_RUN: begin
                if (!sts.rounds_done) begin
                    cmd.step = 1'b1;
                end else if (slot_free) begin
                    // hand the block over once the output beat is free
                    cmd.capture = 1'b1;
                    state_next  = ncre_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ncre_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.capture) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ncre_pkg::ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;

    a_accept_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ncre_pkg::ST_RUN))
        else $error("accepted beat did not start a run");

    a_capture_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> (state_reg == ncre_pkg::ST_RUN && sts.rounds_done && slot_free))
        else $error("capture before rounds finished or onto a held beat");

    a_no_step_and_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.step && cmd.capture) && !(cmd.load && (cmd.step || cmd.capture)))
        else $error("conflicting datapath commands");

    a_valid_from_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.capture))
        else $error("output valid rose without a capture");

endmodule

`default_nettype wire

### verif/ncre_checker.sv
// ----------------------------------------------------------------------------
// ncre_checker
// Watches both stream channels of the nlfsr cipher round engine, works out
// the block that each accepted input beat must produce, and compares every
// output beat in order against it.
// ----------------------------------------------------------------------------
module ncre_checker (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    input  wire logic          s_tready,
    input  wire logic [111:0]  s_tdata,
    input  wire logic          s_tuser,
    input  wire logic          m_tvalid,
    input  wire logic          m_tready,
    input  wire logic [31:0]   m_tdata,
    output int                 fail_count,
    output int                 pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] NLF_LUT = 32'h3A5C742E;
    localparam int MAX_REPORTS = 10;

    logic [31:0] expected_blocks[$];

    // forward rounds shift right and feed the top bit, inverse rounds undo them
    // from the last key index down to the first
    function automatic logic [31:0] cipher_rounds(input logic op, input logic [63:0] key,
                                                  input logic [31:0] blk,
                                                  input logic [5:0] first_kidx,
                                                  input logic [9:0] rounds);
        logic [31:0] st;
        logic [4:0]  tap;
        logic [5:0]  kidx;
        logic        fb;
        int          r;
        st = blk;
        if (op == ncre_pkg::OP_ENCRYPT) begin
            for (r = 0; r < int'(rounds); r++) begin
                kidx = first_kidx + r[5:0];
                tap  = {st[31], st[26], st[20], st[9], st[1]};
                fb   = NLF_LUT[tap] ^ key[kidx] ^ st[16] ^ st[0];
                st   = {fb, st[31:1]};
            end
        end else begin
            for (r = int'(rounds) - 1; r >= 0; r--) begin
                kidx = first_kidx + r[5:0];
                tap  = {st[30], st[25], st[19], st[8], st[0]};
                fb   = st[31] ^ NLF_LUT[tap] ^ key[kidx] ^ st[15];
                st   = {st[30:0], fb};
            end
        end
        return st;
    endfunction

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_blocks.push_back(cipher_rounds(s_tuser, s_tdata[63:0], s_tdata[95:64],
                                                        s_tdata[101:96], s_tdata[111:102]));
            end
            if (m_tvalid && m_tready) begin
                if (expected_blocks.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("[%0t] unexpected output beat: block_out=%08h", $realtime,
                                 m_tdata);
                end else begin
                    want = expected_blocks.pop_front();
                    if (m_tdata !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("[%0t] block_out mismatch: expected %08h got %08h",
                                     $realtime, want, m_tdata);
                    end
                end
            end
            pending_count = expected_blocks.size();
        end
    end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the nlfsr cipher round engine: directed corner
// beats, then a long random mix of encrypt and decrypt beats with random
// back-pressure, one long output stall and one full drain along the way.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BEATS = 1110;
    localparam int STALL_CYCLES = 2500;
    // room for one more item at the largest round_count
    localparam int DRAIN_CYCLES = 1100;

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [111:0]  s_tdata  = '0;
    logic          s_tuser  = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [31:0]   m_tdata;

    int            fail_count;
    int            pending_count;
    bit            quiet        = 1'b0;
    bit            stall_output = 1'b0;

    nlfsr_cipher_round_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ncre_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #60_000_000;
        $display("FAILURE");
        $finish;
    end

    // output side: random back-pressure, plus one long hold-off on request
    initial begin
        int held;
        forever begin
            @(posedge aclk);
            if (stall_output) begin
                stall_output = 1'b0;
                m_tready <= 1'b0;
                for (held = 0; held < STALL_CYCLES; held++) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 99) < 8) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input logic op, input logic [63:0] key, input logic [31:0] blk,
                             input logic [5:0] kofs, input logic [9:0] rounds);
        if (!quiet) begin
            while ($urandom_range(0, 99) < 8) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {rounds, kofs, blk, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    // mostly short runs, a quarter full cipher, the rest anywhere in range
    function automatic logic [9:0] pick_rounds();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 10'($urandom_range(0, 40));
        else if (r < 85)
            return 10'd528;
        return 10'($urandom_range(0, 1023));
    endfunction

    function automatic logic [63:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        else if (r < 8)
            return '1;
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        logic [63:0] key;
        logic [31:0] blk;
        int i;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        key = {$urandom(), $urandom()};
        blk = $urandom();
        // zero rounds pass the block through
        send_beat(ncre_pkg::OP_ENCRYPT, '0, '0, 6'd0, 10'd0);
        send_beat(ncre_pkg::OP_DECRYPT, '0, '0, 6'd0, 10'd0);
        send_beat(ncre_pkg::OP_ENCRYPT, '1, '1, 6'd63, 10'd0);
        send_beat(ncre_pkg::OP_DECRYPT, '1, '1, 6'd63, 10'd0);
        // longest count from the last offset
        send_beat(ncre_pkg::OP_ENCRYPT, '1, '1, 6'd63, 10'd1023);
        send_beat(ncre_pkg::OP_DECRYPT, '1, '1, 6'd63, 10'd1023);
        // full cipher
        send_beat(ncre_pkg::OP_ENCRYPT, '0, 32'hFFFF_FFFF, 6'd0, 10'd528);
        send_beat(ncre_pkg::OP_DECRYPT, '0, '0, 6'd0, 10'd528);
        send_beat(ncre_pkg::OP_ENCRYPT, key, blk, 6'd0, 10'd528);
        send_beat(ncre_pkg::OP_DECRYPT, key, blk, 6'd0, 10'd528);
        // key index wraps right after the first round, then single rounds at offset 1
        send_beat(ncre_pkg::OP_ENCRYPT, key, blk, 6'd63, 10'd2);
        send_beat(ncre_pkg::OP_DECRYPT, key, blk, 6'd63, 10'd2);
        send_beat(ncre_pkg::OP_ENCRYPT, key, blk, 6'd1, 10'd1);
        send_beat(ncre_pkg::OP_DECRYPT, key, blk, 6'd1, 10'd1);
        // beyond the full cipher
        send_beat(ncre_pkg::OP_ENCRYPT, 64'h5A5A_5A5A_5A5A_5A5A, 32'hA5A5_A5A5, 6'd32,
                  10'd600);
        send_beat(ncre_pkg::OP_DECRYPT, 64'hA5A5_A5A5_A5A5_A5A5, 32'h5A5A_5A5A, 6'd31,
                  10'd1000);
        // single key bits at both ends of the key
        send_beat(ncre_pkg::OP_ENCRYPT, 64'h8000_0000_0000_0000, 32'h8000_0000, 6'd63,
                  10'd64);
        send_beat(ncre_pkg::OP_DECRYPT, 64'h0000_0000_0000_0001, 32'h0000_0001, 6'd0,
                  10'd65);
        wait_drained();

        for (i = 0; i < RANDOM_BEATS; i++) begin
            if (i == 100)
                stall_output = 1'b1;
            if (i == 400)
                quiet = 1'b1;
            if (i == 600)
                quiet = 1'b0;
            if (i == 750)
                wait_drained();
            if (i >= 100 && i < 130)
                send_beat(1'($urandom()), pick_key(), $urandom(), 6'($urandom()),
                          10'($urandom_range(0, 20)));
            else
                send_beat(1'($urandom()), pick_key(), $urandom(), 6'($urandom()),
                          pick_rounds());
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
